// ===== design/gtg_pkg.sv =====
// Shared types, constants and stage functions for the go-to-goal drive controller.
// No dependencies; the top level takes it in by wildcard import.
package gtg_pkg;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_GOAL_X        = 3'd0,
		REG_GOAL_Y        = 3'd1,
		REG_HEADING_GAIN  = 3'd2,
		REG_DISTANCE_GAIN = 3'd3,
		REG_SPEED_LIMIT   = 3'd4
	} reg_idx_t;

	localparam logic [23:0] HEADING_GAIN_RST  = 24'd167772;
	localparam logic [23:0] DISTANCE_GAIN_RST = 24'd16777;
	localparam logic [14:0] SPEED_LIMIT_RST   = 15'd1229;

	localparam int CSQ_STEPS    = 16;   // root bits of the quaternion cosine
	localparam int DSQ_STEPS    = 29;   // root bits of the distance
	localparam int NORM_IDX     = CSQ_STEPS;
	localparam int CORDIC_STEPS = 22;
	localparam int MID_STAGES   = NORM_IDX + 1 + CORDIC_STEPS;

	// angles in degrees with 16 fraction bits
	localparam logic signed [25:0] BEAR_RIGHT = 26'sd5898240;   // 90 degrees
	localparam logic signed [25:0] ERR_LIMIT  = 26'sd2949120;   // 45 degrees

	localparam logic signed [23:0] ATAN_TAB [CORDIC_STEPS] = '{
		24'sd2949120, 24'sd1740967, 24'sd919879, 24'sd466945, 24'sd234379,
		24'sd117304, 24'sd58666, 24'sd29335, 24'sd14668, 24'sd7334, 24'sd3667,
		24'sd1833, 24'sd917, 24'sd458, 24'sd229, 24'sd115, 24'sd57, 24'sd29,
		24'sd14, 24'sd7, 24'sd4, 24'sd2
	};

	typedef struct packed {
		logic signed [34:0] x;
		logic signed [34:0] y;
		logic signed [23:0] z;
	} cord_t;

	typedef struct packed {
		logic [30:0] crem;
		logic [15:0] croot;
		logic [57:0] drem;
		logic [28:0] droot;
		cord_t       h;
		cord_t       b;
		logic        rev;
		logic        dxz;
		logic        dypos;
		logic        dyneg;
	} mid_t;

	// double x and y until the larger magnitude reaches bit 30
	function automatic cord_t norm_pair(input cord_t c);
		cord_t       n;
		logic [30:0] ax;
		logic [30:0] ay;
		logic [30:0] mag;
		logic [4:0]  sh;
		n  = c;
		ax = c.x[30:0];
		ay = c.y[34] ? 31'(-c.y) : c.y[30:0];
		mag = (ax > ay) ? ax : ay;
		sh = 5'd0;
		for (int i = 0; i < 31; i++) begin
			if (mag[i])
				sh = 5'(30 - i);
		end
		n.x = c.x <<< sh;
		n.y = c.y <<< sh;
		return n;
	endfunction

	function automatic cord_t cordic_step(input cord_t c, input int i);
		cord_t n;
		n = c;
		if (c.y >= 0) begin
			n.x = c.x + (c.y >>> i);
			n.y = c.y - (c.x >>> i);
			n.z = c.z + ATAN_TAB[i];
		end else begin
			n.x = c.x - (c.y >>> i);
			n.y = c.y + (c.x >>> i);
			n.z = c.z - ATAN_TAB[i];
		end
		return n;
	endfunction

	// one stage of the shared middle pipeline: root digits, normalise, rotate
	function automatic mid_t mid_step(input mid_t cur, input int m);
		mid_t        nxt;
		logic [31:0] ct;
		logic [58:0] dt;
		int          b;
		nxt = cur;
		if (m < CSQ_STEPS) begin
			b  = CSQ_STEPS - 1 - m;
			ct = ({16'd0, cur.croot} << (b + 1)) + (32'd1 << (2 * b));
			if ({1'b0, cur.crem} >= ct) begin
				nxt.crem  = cur.crem - ct[30:0];
				nxt.croot = cur.croot | (16'd1 << b);
			end
		end
		if (m < DSQ_STEPS) begin
			b  = DSQ_STEPS - 1 - m;
			dt = ({30'd0, cur.droot} << (b + 1)) + (59'd1 << (2 * b));
			if ({1'b0, cur.drem} >= dt) begin
				nxt.drem  = cur.drem - dt[57:0];
				nxt.droot = cur.droot | (29'd1 << b);
			end
		end
		if (m == NORM_IDX) begin
			nxt.h.x = 35'({19'd0, cur.croot});
			nxt.h   = norm_pair(nxt.h);
			nxt.b   = norm_pair(cur.b);
		end
		if (m > NORM_IDX) begin
			nxt.h = cordic_step(cur.h, m - NORM_IDX - 1);
			nxt.b = cordic_step(cur.b, m - NORM_IDX - 1);
		end
		return nxt;
	endfunction

endpackage

// ===== design/go_to_goal_drive_controller.sv =====
// Go-to-goal drive controller: pose in, angular and linear drive out.
// Depends on gtg_pkg for types, constants and the stage functions.
//
// channel   direction  handshake                 payload
// pose      in         pose_valid / pose_stall   pos_x_mm, pos_y_mm, orientation_z
// drive     out        drive_valid / drive_stall angular_drive, linear_drive
// config    in         APB write / read          goal, gains, speed limit
//
// One pose a cycle while pose_stall is low. Depth is set by the 16 cosine root digits,
// normalisation and 22 CORDIC rotations, one per stage; the 29 distance root digits
// run in parallel in the same stages.
// Reset clears valid bits, the start point latch and the registers to defaults.
// A stalled result moves into a skid register; while that is full the pipe holds
// and pose_stall is high.
module go_to_goal_drive_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pose_valid,
	output logic                pose_stall,
	input  logic signed [23:0]  pos_x_mm,
	input  logic signed [23:0]  pos_y_mm,
	input  logic signed [15:0]  orientation_z,
	output logic                drive_valid,
	input  logic                drive_stall,
	output logic signed [15:0]  angular_drive,
	output logic signed [15:0]  linear_drive,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import gtg_pkg::*;

	logic signed [23:0] goal_x_q, goal_y_q;
	logic [23:0]        heading_gain_q, distance_gain_q;
	logic [14:0]        speed_limit_q;
	logic signed [23:0] start_x_q, start_y_q;
	logic               start_taken_q;

	logic               adv, take;
	logic signed [23:0] sx, sy;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [MID_STAGES-1:0]    v_mid;
	logic signed [24:0] dx_s1, dy_s1, rdx_s1, rdy_s1, gdx_s1, gdy_s1;
	logic signed [15:0] qz_s1;
	logic signed [24:0] dx_s2, dy_s2;
	logic signed [15:0] qz_s2;
	logic [30:0]        qsq_s2;
	logic [47:0]        dxsq_s2, dysq_s2, rxsq_s2, rysq_s2, gxsq_s2, gysq_s2;
	mid_t               pre_s3;
	mid_t               pre_d;
	mid_t               mid_s [MID_STAGES];
	logic signed [25:0] err_s4;
	logic [28:0]        droot_s4;
	logic               rev_s4;
	logic signed [50:0] aprod_s5;
	logic [52:0]        lprod_s5;
	logic               big_s5, rev_s5;
	logic signed [15:0] ang_s6, lin_s6;
	logic signed [15:0] skid_ang_q, skid_lin_q;
	logic               skid_v_q;

	logic [48:0]        rsum, gsum;
	logic signed [25:0] bxn, byn;
	logic signed [24:0] head;
	logic signed [25:0] bear;
	logic signed [51:0] aro;
	logic signed [23:0] ash;
	logic [53:0]        lro;
	logic [37:0]        lu;
	logic [14:0]        lc;
	logic signed [15:0] ls, as16;
	mid_t               mid_last;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q        <= '0;
			goal_y_q        <= '0;
			heading_gain_q  <= HEADING_GAIN_RST;
			distance_gain_q <= DISTANCE_GAIN_RST;
			speed_limit_q   <= SPEED_LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_GOAL_X:        goal_x_q        <= pwdata[23:0];
				REG_GOAL_Y:        goal_y_q        <= pwdata[23:0];
				REG_HEADING_GAIN:  heading_gain_q  <= pwdata[23:0];
				REG_DISTANCE_GAIN: distance_gain_q <= pwdata[23:0];
				REG_SPEED_LIMIT:   speed_limit_q   <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_GOAL_X:        prdata = 32'(goal_x_q);
			REG_GOAL_Y:        prdata = 32'(goal_y_q);
			REG_HEADING_GAIN:  prdata = {8'd0, heading_gain_q};
			REG_DISTANCE_GAIN: prdata = {8'd0, distance_gain_q};
			REG_SPEED_LIMIT:   prdata = {17'd0, speed_limit_q};
			default:           prdata = '0;
		endcase
	end

	// flow control: the whole pipe advances unless the skid register is full
	assign adv        = !skid_v_q;
	assign pose_stall = skid_v_q;
	assign take       = pose_valid && adv;

	// the first pose is its own start point
	assign sx = start_taken_q ? start_x_q : pos_x_mm;
	assign sy = start_taken_q ? start_y_q : pos_y_mm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_taken_q <= 1'b0;
			start_x_q     <= '0;
			start_y_q     <= '0;
		end else if (take && !start_taken_q) begin
			start_taken_q <= 1'b1;
			start_x_q     <= pos_x_mm;
			start_y_q     <= pos_y_mm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_mid <= '0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
		end else if (adv) begin
			v_s1  <= pose_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_mid <= {v_mid[MID_STAGES-2:0], v_s3};
			v_s4  <= v_mid[MID_STAGES-1];
			v_s5  <= v_s4;
			v_s6  <= v_s5;
		end
	end

	// stage 1: differences
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= 25'(goal_x_q) - 25'(pos_x_mm);
			dy_s1  <= 25'(goal_y_q) - 25'(pos_y_mm);
			rdx_s1 <= 25'(pos_x_mm) - 25'(sx);
			rdy_s1 <= 25'(pos_y_mm) - 25'(sy);
			gdx_s1 <= 25'(goal_x_q) - 25'(sx);
			gdy_s1 <= 25'(goal_y_q) - 25'(sy);
			qz_s1  <= orientation_z;
		end
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			qz_s2   <= qz_s1;
			qsq_s2  <= 31'(qz_s1 * qz_s1);
			dxsq_s2 <= 48'(dx_s1 * dx_s1);
			dysq_s2 <= 48'(dy_s1 * dy_s1);
			rxsq_s2 <= 48'(rdx_s1 * rdx_s1);
			rysq_s2 <= 48'(rdy_s1 * rdy_s1);
			gxsq_s2 <= 48'(gdx_s1 * gdx_s1);
			gysq_s2 <= 48'(gdy_s1 * gdy_s1);
		end
	end

	// stage 3: sums, reverse decision, bearing operands folded to x >= 0
	always_comb begin
		rsum = {1'b0, rxsq_s2} + {1'b0, rysq_s2};
		gsum = {1'b0, gxsq_s2} + {1'b0, gysq_s2};
		bxn  = dx_s2[24] ? -26'(dx_s2) : 26'(dx_s2);
		byn  = dx_s2[24] ? -26'(dy_s2) : 26'(dy_s2);
		pre_d        = '0;
		pre_d.crem   = 31'h4000_0000 - qsq_s2;
		pre_d.drem   = {1'b0, ({1'b0, dxsq_s2} + {1'b0, dysq_s2}), 8'd0};
		pre_d.h.y    = 35'(qz_s2);
		pre_d.b.x    = 35'(bxn);
		pre_d.b.y    = 35'(byn);
		pre_d.rev    = rsum > gsum;
		pre_d.dxz    = dx_s2 == '0;
		pre_d.dypos  = !dy_s2[24] && dy_s2 != '0;
		pre_d.dyneg  = dy_s2[24];
	end

	always_ff @(posedge clk) begin
		if (adv)
			pre_s3 <= pre_d;
	end

	// square root digits, normalisation and CORDIC rotations
	for (genvar g = 0; g < MID_STAGES; g++) begin : g_mid
		if (g == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv)
					mid_s[g] <= mid_step(pre_s3, g);
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv)
					mid_s[g] <= mid_step(mid_s[g-1], g);
			end
		end
	end

	assign mid_last = mid_s[MID_STAGES-1];

	// stage 4: heading error
	always_comb begin
		head = {mid_last.h.z, 1'b0};
		if (mid_last.dxz)
			bear = mid_last.dypos ? BEAR_RIGHT : (mid_last.dyneg ? -BEAR_RIGHT : 26'sd0);
		else
			bear = 26'(mid_last.b.z);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s4   <= 26'(head) - bear;
			droot_s4 <= mid_last.droot;
			rev_s4   <= mid_last.rev;
		end
	end

	// stage 5: gain products
	always_ff @(posedge clk) begin
		if (adv) begin
			aprod_s5 <= 51'($signed({1'b0, heading_gain_q}) * err_s4);
			lprod_s5 <= 53'(distance_gain_q * droot_s4);
			big_s5   <= err_s4 > ERR_LIMIT || err_s4 < -ERR_LIMIT;
			rev_s5   <= rev_s4;
		end
	end

	// stage 6: round, saturate, limit
	always_comb begin
		aro = 52'(aprod_s5) + 52'sd134217728;
		ash = 24'(aro >>> 28);
		if (ash > 24'sd32767)
			as16 = 16'sh7fff;
		else if (ash < -24'sd32768)
			as16 = -16'sh8000;
		else
			as16 = ash[15:0];
		lro = 54'(lprod_s5) + 54'd32768;
		lu  = lro[53:16];
		lc  = (lu > 38'(speed_limit_q)) ? speed_limit_q : lu[14:0];
		ls  = rev_s5 ? -$signed({1'b0, lc}) : $signed({1'b0, lc});
		if (big_s5)
			ls = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s6 <= as16;
			lin_s6 <= ls;
		end
	end

	// skid register: catch the last stage's item when the output stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!drive_stall)
				skid_v_q <= 1'b0;
		end else if (v_s6 && drive_stall) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && v_s6 && drive_stall) begin
			skid_ang_q <= ang_s6;
			skid_lin_q <= lin_s6;
		end
	end

	assign drive_valid   = skid_v_q || v_s6;
	assign angular_drive = skid_v_q ? skid_ang_q : ang_s6;
	assign linear_drive  = skid_v_q ? skid_lin_q : lin_s6;

endmodule

// ===== dv/go_to_goal_drive_controller_tb.sv =====
// Testbench for go_to_goal_drive_controller: drives poses and APB register writes,
// predicts drive items with an in-bench fixed-point model and checks each in order.
// Depends on gtg_pkg for the register indexes.
`timescale 1ns / 1ps
module go_to_goal_drive_controller_tb;
	import gtg_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               pose_valid;
	logic               pose_stall;
	logic signed [23:0] pos_x_mm;
	logic signed [23:0] pos_y_mm;
	logic signed [15:0] orientation_z;
	logic               drive_valid;
	logic               drive_stall;
	logic signed [15:0] angular_drive;
	logic signed [15:0] linear_drive;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	go_to_goal_drive_controller uut (.*);

	typedef struct packed {
		logic signed [15:0] ang;
		logic signed [15:0] lin;
	} drive_t;

	// predictor copy of registers and start latch
	longint goal_x, goal_y, heading_gain, distance_gain, speed_limit;
	longint start_x, start_y;
	bit     start_taken;

	drive_t drive_q[$];
	int     errors;
	int     send_idle, recv_idle;
	int     n_items, n_checked;

	const longint ATAN_DEG[22] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
	};

	function automatic longint shr_floor(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint atan_deg(longint x, longint y);
		longint ay, m, z, nx, ny;
		ay = y < 0 ? -y : y;
		m  = x > ay ? x : ay;
		z  = 0;
		if (m == 0)
			return 0;
		while (m < (64'sd1 << 30)) begin
			x *= 2;
			y *= 2;
			m *= 2;
		end
		for (int i = 0; i < 22; i++) begin
			if (y >= 0) begin
				nx = x + shr_floor(y, i);
				ny = y - shr_floor(x, i);
				z += ATAN_DEG[i];
			end else begin
				nx = x - shr_floor(y, i);
				ny = y + shr_floor(x, i);
				z -= ATAN_DEG[i];
			end
			x = nx;
			y = ny;
		end
		return z;
	endfunction

	function automatic drive_t predict_drive(longint px, longint py, longint qz);
		longint c, heading, bearing, dx, dy, bx, by, err, aerr, ang, lin, span;
		longint rr, gg;
		drive_t d;
		if (!start_taken) begin
			start_x = px;
			start_y = py;
			start_taken = 1;
		end
		c = int_sqrt((64'd1 << 30) - qz * qz);
		heading = 2 * atan_deg(c, qz);
		dx = goal_x - px;
		dy = goal_y - py;
		if (dx == 0) begin
			bearing = dy > 0 ? 90 * 65536 : (dy < 0 ? -90 * 65536 : 0);
		end else begin
			bx = dx;
			by = dy;
			if (bx < 0) begin
				bx = -bx;
				by = -by;
			end
			bearing = atan_deg(bx, by);
		end
		err = heading - bearing;
		ang = (heading_gain * err + (64'sd1 << 27)) >>> 28;
		if (ang > 32767)
			ang = 32767;
		if (ang < -32768)
			ang = -32768;
		span = int_sqrt((dx * dx + dy * dy) << 8);
		lin = (distance_gain * span + (64'sd1 << 15)) >>> 16;
		if (lin > speed_limit)
			lin = speed_limit;
		rr = (px - start_x) * (px - start_x) + (py - start_y) * (py - start_y);
		gg = (goal_x - start_x) * (goal_x - start_x)
			+ (goal_y - start_y) * (goal_y - start_y);
		if (rr > gg)
			lin = -lin;
		aerr = err < 0 ? -err : err;
		if (aerr > 45 * 65536)
			lin = 0;
		d.ang = 16'(ang);
		d.lin = 16'(lin);
		return d;
	endfunction

	always #5 clk = ~clk;

	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(idx) << 2;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_GOAL_X:        goal_x = longint'(signed'(val[23:0]));
			REG_GOAL_Y:        goal_y = longint'(signed'(val[23:0]));
			REG_HEADING_GAIN:  heading_gain = val[23:0];
			REG_DISTANCE_GAIN: distance_gain = val[23:0];
			REG_SPEED_LIMIT:   speed_limit = val[14:0];
			default: ;
		endcase
	endtask

	// drop valid, hold until all drive items are back, then pad out the pipe latency
	task automatic drain();
		pose_valid <= 1'b0;
		while (drive_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_pose(logic [23:0] x, logic [23:0] y, logic [15:0] q);
		while ($urandom_range(99) < send_idle) begin
			pose_valid <= 1'b0;
			@(posedge clk);
		end
		pose_valid    <= 1'b1;
		pos_x_mm      <= x;
		pos_y_mm      <= y;
		orientation_z <= q;
		@(posedge clk);
		while (pose_stall)
			@(posedge clk);
		drive_q.push_back(predict_drive(longint'(signed'(x)), longint'(signed'(y)),
			longint'(signed'(q))));
		n_items++;
	endtask

	// receiver: random stall, check accepted items against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (drive_valid && !drive_stall) begin
				if (drive_q.size() == 0) begin
					$display("%0t unexpected drive item ang=%0d lin=%0d", $time,
						angular_drive, linear_drive);
					errors++;
				end else begin
					if (drive_q[0].ang !== angular_drive) begin
						$display("%0t angular_drive expected %0d actual %0d", $time,
							drive_q[0].ang, angular_drive);
						errors++;
					end
					if (drive_q[0].lin !== linear_drive) begin
						$display("%0t linear_drive expected %0d actual %0d", $time,
							drive_q[0].lin, linear_drive);
						errors++;
					end
					void'(drive_q.pop_front());
					n_checked++;
				end
			end
			drive_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(3))
			0: return 24'($urandom_range(4000)) - 24'd2000;
			1: return 24'($urandom);
			2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
			default: return 24'($urandom_range(200000)) - 24'd100000;
		endcase
	endfunction

	typedef struct {
		logic [23:0] x;
		logic [23:0] y;
		logic [15:0] q;
	} pose_row_t;

	pose_row_t dir_tab[$];

	initial begin
		clk = 0;
		arst_n = 0;
		pose_valid = 0;
		pos_x_mm = '0;
		pos_y_mm = '0;
		orientation_z = '0;
		drive_stall = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		n_items = 0;
		n_checked = 0;
		goal_x = 0;
		goal_y = 0;
		heading_gain = 167772;
		distance_gain = 16777;
		speed_limit = 1229;
		start_x = 0;
		start_y = 0;
		start_taken = 0;
		send_idle = 10;
		recv_idle = 72;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// pose at the goal with zero heading after reset: both drives zero
		@(posedge clk);
		pose_valid <= 1'b1;
		pos_x_mm <= '0;
		pos_y_mm <= '0;
		orientation_z <= '0;
		@(posedge clk);
		while (pose_stall)
			@(posedge clk);
		drive_q.push_back('{ang: 16'sd0, lin: 16'sd0});
		start_taken = 1;
		n_items++;
		drain();

		reg_write(REG_GOAL_X, 32'd1000);
		reg_write(REG_GOAL_Y, 32'hFFFFFC18);
		dir_tab = '{
			'{24'd1000, 24'd0, 16'd0},          // goal straight below
			'{24'd1000, 24'hFFF000, 16'd0},     // goal straight above
			'{24'd1000, 24'hFFFC18, 16'h8000},  // quaternion at -1, on goal
			'{24'd0, 24'd0, 16'h7FFF},
			'{24'd0, 24'd0, 16'h8000},
			'{24'h7FFFFF, 24'h7FFFFF, 16'd0},
			'{24'h800000, 24'h800000, 16'd0},
			'{24'h7FFFFF, 24'h800000, 16'h5A82},
			'{24'h800000, 24'h7FFFFF, 16'hA57E},
			'{24'd2000, 24'hFFF830, 16'd0},     // beyond goal: reverse
			'{24'd1000, 24'd1000, 16'd0},       // equal distance: forward
			'{24'd500, 24'hFFFE0C, 16'h2000},
			'{24'd100, 24'd0, 16'h4000}         // large error
		};
		foreach (dir_tab[i])
			send_pose(dir_tab[i].x, dir_tab[i].y, dir_tab[i].q);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle = 72;
				recv_idle = 10;
			end
			if (ph == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			case (ph)
				0: begin
					reg_write(REG_HEADING_GAIN, 32'hFFFFFF);
					reg_write(REG_DISTANCE_GAIN, 32'hFFFFFF);
					reg_write(REG_SPEED_LIMIT, 32'h7FFF);
				end
				1: begin
					reg_write(REG_HEADING_GAIN, 32'd0);
					reg_write(REG_DISTANCE_GAIN, 32'd0);
					reg_write(REG_SPEED_LIMIT, 32'd0);
				end
				default: begin
					reg_write(REG_HEADING_GAIN, $urandom);
					reg_write(REG_DISTANCE_GAIN, $urandom_range(70000));
					reg_write(REG_SPEED_LIMIT, $urandom);
				end
			endcase
			reg_write(REG_GOAL_X, {8'd0, rand_coord()});
			reg_write(REG_GOAL_Y, {8'd0, rand_coord()});
			for (int k = 0; k < 250; k++) begin
				if (k == 125)
					drain();
				send_pose(rand_coord(), rand_coord(),
					$urandom_range(3) == 0 ? 16'($urandom) :
					16'($urandom_range(20000)) - 16'd10000);
			end
			drain();
		end

		$display("Checked %0d of %0d drive items over six register settings,",
			n_checked, n_items);
		$display("including directed edges, reverse and large-error cases.");
		if (errors == 0 && drive_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
